// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the list core; the including module supplies clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, quiet while in reset
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, quiet while in reset
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/idll_pkg.sv =====
// Shared types, codes and the microcode table of the linked-list core.
package idll_pkg;

	localparam int NODE_DEPTH_DEF  = 1024;
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int IW   = 11;
	localparam int KW   = 3;
	localparam int NCW  = 11;
	localparam int SW   = 2;
	localparam int PCW  = 4;

	typedef logic signed [IW-1:0] idx_t;
	typedef logic [SW-1:0] status_t;
	typedef logic [PCW-1:0] pc_t;

	localparam idx_t NONE_IDX = {IW{1'b1}};

	// request kinds
	localparam logic [KW-1:0] KIND_SET_ENDS  = KW'(0);
	localparam logic [KW-1:0] KIND_LOAD      = KW'(1);
	localparam logic [KW-1:0] KIND_DELETE    = KW'(2);
	localparam logic [KW-1:0] KIND_INS_AFTER = KW'(3);
	localparam logic [KW-1:0] KIND_INS_BEFOR = KW'(4);
	localparam logic [KW-1:0] KIND_READ      = KW'(5);

	// result status codes
	localparam status_t ST_OK    = SW'(0);
	localparam status_t ST_FULL  = SW'(1);
	localparam status_t ST_RANGE = SW'(2);

	typedef enum logic [1:0] {ADDR_IDX, ADDR_FREE, ADDR_PV, ADDR_NX} addr_sel_t;
	typedef enum logic [1:0] {WN_NONE, WN_LNEXT, WN_NX, WN_NEW} nsel_t;
	typedef enum logic [1:0] {WP_NONE, WP_LPREV, WP_PV, WP_NEW} psel_t;
	typedef enum logic [2:0] {CHK_NONE, CHK_ENDS, CHK_LOAD, CHK_NODE, CHK_INSERT} chk_t;
	typedef enum logic [2:0] {
		ACT_NONE, ACT_SET_ENDS, ACT_GRAB_DEL, ACT_GRAB_AFTER,
		ACT_GRAB_BEFORE, ACT_GRAB_READ, ACT_HEAD_LINK, ACT_TAIL_LINK
	} act_t;
	typedef enum logic [1:0] {NX_STEP, NX_JUMP, NX_DONE} seq_t;

	// one control word of the microprogram
	typedef struct packed {
		addr_sel_t addr;
		logic      wr_val;
		nsel_t     wr_next;
		psel_t     wr_prev;
		chk_t      chk;
		act_t      act;
		logic      bump;
		seq_t      seq;
		pc_t       target;
	} uword_t;

	// sequencer to datapath control group
	typedef struct packed {
		logic   start;
		logic   en;
		logic   finish;
		uword_t uw;
	} ctl_t;

	// store write enables
	typedef struct packed {
		logic val;
		logic nxt;
		logic prv;
	} we_t;

	// microprogram entry points and steps
	localparam pc_t PC_SET  = PCW'(0);
	localparam pc_t PC_LOAD = PCW'(1);
	localparam pc_t PC_DEL0 = PCW'(2);
	localparam pc_t PC_DEL1 = PCW'(3);
	localparam pc_t PC_DEL2 = PCW'(4);
	localparam pc_t PC_DEL3 = PCW'(5);
	localparam pc_t PC_INA0 = PCW'(6);
	localparam pc_t PC_INA1 = PCW'(7);
	localparam pc_t PC_INB0 = PCW'(8);
	localparam pc_t PC_INB1 = PCW'(9);
	localparam pc_t PC_INS0 = PCW'(10);
	localparam pc_t PC_INS1 = PCW'(11);
	localparam pc_t PC_INS2 = PCW'(12);
	localparam pc_t PC_RD0  = PCW'(13);
	localparam pc_t PC_RD1  = PCW'(14);
	localparam pc_t PC_NOP  = PCW'(15);

	function automatic uword_t ucode(input pc_t pc);
		uword_t uw;
		uw = '{addr: ADDR_IDX, wr_val: 1'b0, wr_next: WN_NONE, wr_prev: WP_NONE,
			chk: CHK_NONE, act: ACT_NONE, bump: 1'b0, seq: NX_STEP, target: PC_SET};
		case (pc)
			PC_SET: begin
				uw.chk = CHK_ENDS; uw.act = ACT_SET_ENDS; uw.seq = NX_DONE;
			end
			PC_LOAD: begin
				uw.chk = CHK_LOAD; uw.wr_val = 1'b1;
				uw.wr_next = WN_LNEXT; uw.wr_prev = WP_LPREV; uw.seq = NX_DONE;
			end
			PC_DEL0: uw.chk = CHK_NODE;
			PC_DEL1: uw.act = ACT_GRAB_DEL;
			PC_DEL2: begin
				uw.addr = ADDR_PV; uw.wr_next = WN_NX; uw.act = ACT_HEAD_LINK;
			end
			PC_DEL3: begin
				uw.addr = ADDR_NX; uw.wr_prev = WP_PV; uw.act = ACT_TAIL_LINK;
				uw.seq = NX_DONE;
			end
			PC_INA0: uw.chk = CHK_INSERT;
			PC_INA1: begin
				uw.act = ACT_GRAB_AFTER; uw.seq = NX_JUMP; uw.target = PC_INS0;
			end
			PC_INB0: uw.chk = CHK_INSERT;
			PC_INB1: uw.act = ACT_GRAB_BEFORE;
			PC_INS0: begin
				uw.addr = ADDR_FREE; uw.wr_val = 1'b1;
				uw.wr_next = WN_NX; uw.wr_prev = WP_PV;
			end
			PC_INS1: begin
				uw.addr = ADDR_PV; uw.wr_next = WN_NEW; uw.act = ACT_HEAD_LINK;
			end
			PC_INS2: begin
				uw.addr = ADDR_NX; uw.wr_prev = WP_NEW; uw.act = ACT_TAIL_LINK;
				uw.bump = 1'b1; uw.seq = NX_DONE;
			end
			PC_RD0: uw.chk = CHK_NODE;
			PC_RD1: begin
				uw.act = ACT_GRAB_READ; uw.seq = NX_DONE;
			end
			PC_NOP: uw.seq = NX_DONE;
			default: uw.seq = NX_DONE;
		endcase
		return uw;
	endfunction

	function automatic pc_t entry_pc(input logic [KW-1:0] kind);
		pc_t pc;
		case (kind)
			KIND_SET_ENDS:  pc = PC_SET;
			KIND_LOAD:      pc = PC_LOAD;
			KIND_DELETE:    pc = PC_DEL0;
			KIND_INS_AFTER: pc = PC_INA0;
			KIND_INS_BEFOR: pc = PC_INB0;
			KIND_READ:      pc = PC_RD0;
			default:        pc = PC_NOP;
		endcase
		return pc;
	endfunction

	function automatic logic is_node(input idx_t i, input int depth);
		return !i[IW-1] && (int'(i) < depth);
	endfunction

	function automatic logic is_link(input idx_t i, input int depth);
		return (i == NONE_IDX) || is_node(i, depth);
	endfunction

endpackage

// ===== rtl/core/indexed_doubly_linked_list.sv =====
// Top level of the indexed doubly linked list core.
// Usage:
//   Input channel in_valid/in_stall carries one request: kind, node_index,
//   node_value, link_next, link_prev, node_count. A request is taken on a
//   rising edge with in_valid high and in_stall low.
//   Output channel out_valid/out_stall returns exactly one result per request.
// Timing: in_stall is high while a request is being worked. After its
//   acceptance a request runs its microprogram steps in order; a range or
//   full error ends at the first step. The result register is loaded by the
//   last step. Every node access goes through one shared store address,
//   which sets the step count; the next request may be taken the cycle the
//   result appears.
// Stall: a result waits in the output register; the next request runs up to
//   its last step and holds there until the waiting result is taken.
// Reset: arst_n clears the list to empty (head and tail -1, free counter 0)
//   and idles the sequencer; node store contents stay undefined until written.
`include "assert_macros.svh"

module indexed_doubly_linked_list #(
	parameter int NODE_DEPTH  = idll_pkg::NODE_DEPTH_DEF,
	parameter int VALUE_WIDTH = idll_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [idll_pkg::KW-1:0]       kind,
	input  idll_pkg::idx_t                node_index,
	input  logic signed [VALUE_WIDTH-1:0] node_value,
	input  idll_pkg::idx_t                link_next,
	input  idll_pkg::idx_t                link_prev,
	input  logic [idll_pkg::NCW-1:0]      node_count,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [VALUE_WIDTH-1:0] out_value,
	output idll_pkg::idx_t                out_index,
	output idll_pkg::idx_t                out_next,
	output idll_pkg::idx_t                out_prev,
	output idll_pkg::idx_t                head_index,
	output idll_pkg::idx_t                tail_index,
	output idll_pkg::status_t             status
);
	import idll_pkg::*;

	localparam int AW = $clog2(NODE_DEPTH);

	ctl_t                   ctl;
	logic                   busy;
	logic                   accept;
	logic                   out_free;
	logic                   chk_fail;
	logic                   out_valid_q;
	logic [AW-1:0]          addr;
	we_t                    we;
	logic [VALUE_WIDTH-1:0] wval, rval;
	idx_t                   wnext, wprev, rnext, rprev;

	assign in_stall  = busy;
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	idll_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.kind     (kind),
		.chk_fail (chk_fail),
		.out_free (out_free),
		.ctl      (ctl),
		.busy     (busy)
	);

	idll_dp #(
		.NODE_DEPTH  (NODE_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.node_index (node_index),
		.node_value (node_value),
		.link_next  (link_next),
		.link_prev  (link_prev),
		.node_count (node_count),
		.rval       (rval),
		.rnext      (rnext),
		.rprev      (rprev),
		.addr       (addr),
		.we         (we),
		.wval       (wval),
		.wnext      (wnext),
		.wprev      (wprev),
		.chk_fail   (chk_fail),
		.out_value  (out_value),
		.out_index  (out_index),
		.out_next   (out_next),
		.out_prev   (out_prev),
		.head_index (head_index),
		.tail_index (tail_index),
		.status     (status)
	);

	idll_store #(
		.NODE_DEPTH  (NODE_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_store (
		.clk   (clk),
		.addr  (addr),
		.we    (we),
		.wval  (wval),
		.wnext (wnext),
		.wprev (wprev),
		.rval  (rval),
		.rnext (rnext),
		.rprev (rprev)
	);

	// hold the result until taken; raise on a finishing step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.en && ctl.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	`ASSERT_NEXT(a_accept_busy, accept, busy, "accepted request did not start the sequencer")
	`ASSERT_IMPL(a_no_overwrite, out_valid && out_stall, !(ctl.en && ctl.finish),
		"finishing step ran over a stalled result")
	`ASSERT_NEXT(a_finish_valid, ctl.en && ctl.finish, out_valid,
		"finished request produced no result")
	`ASSERT_IMPL(a_idle_quiet, !busy, !ctl.en && (we == '0), "store touched while idle")

endmodule

// ===== rtl/core/idll_store.sv =====
// Node store: value, next and prev arrays on one shared address, registered read.
module idll_store #(
	parameter int NODE_DEPTH  = idll_pkg::NODE_DEPTH_DEF,
	parameter int VALUE_WIDTH = idll_pkg::VALUE_WIDTH_DEF,
	localparam int AW = $clog2(NODE_DEPTH)
) (
	input  logic                   clk,
	input  logic [AW-1:0]          addr,
	input  idll_pkg::we_t          we,
	input  logic [VALUE_WIDTH-1:0] wval,
	input  idll_pkg::idx_t         wnext,
	input  idll_pkg::idx_t         wprev,
	output logic [VALUE_WIDTH-1:0] rval,
	output idll_pkg::idx_t         rnext,
	output idll_pkg::idx_t         rprev
);
	import idll_pkg::*;

	logic [VALUE_WIDTH-1:0] val_mem  [NODE_DEPTH];
	idx_t                   next_mem [NODE_DEPTH];
	idx_t                   prev_mem [NODE_DEPTH];

	// write and read the value array
	always_ff @(posedge clk) begin
		if (we.val) val_mem[addr] <= wval;
		rval <= val_mem[addr];
	end

	// write and read the next-link array
	always_ff @(posedge clk) begin
		if (we.nxt) next_mem[addr] <= wnext;
		rnext <= next_mem[addr];
	end

	// write and read the prev-link array
	always_ff @(posedge clk) begin
		if (we.prv) prev_mem[addr] <= wprev;
		rprev <= prev_mem[addr];
	end

endmodule

// ===== rtl/core/idll_seq.sv =====
// Microprogram sequencer: step counter, control table look-up and exit jumps.
module idll_seq (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [idll_pkg::KW-1:0]  kind,
	input  logic                     chk_fail,
	input  logic                     out_free,
	output idll_pkg::ctl_t           ctl,
	output logic                     busy
);
	import idll_pkg::*;

	pc_t    pc_q;
	logic   busy_q;
	uword_t uw;
	logic   finish;
	logic   en;

	// decode the current step; hold a finishing step until the result slot frees
	always_comb begin
		uw     = ucode(pc_q);
		finish = busy_q && ((uw.seq == NX_DONE) || chk_fail);
		en     = busy_q && (!finish || out_free);
		ctl    = '{start: start, en: en, finish: finish, uw: uw};
	end

	assign busy = busy_q;

	// advance, jump or drop out of the program
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= PC_NOP;
		end else if (start) begin
			busy_q <= 1'b1;
			pc_q   <= entry_pc(kind);
		end else if (en) begin
			if (finish) begin
				busy_q <= 1'b0;
			end else if (uw.seq == NX_JUMP) begin
				pc_q <= uw.target;
			end else begin
				pc_q <= pc_q + PCW'(1);
			end
		end
	end

endmodule

// ===== rtl/core/idll_dp.sv =====
// Datapath: request registers, list ends, free counter, checks, link muxes and results.
module idll_dp #(
	parameter int NODE_DEPTH  = idll_pkg::NODE_DEPTH_DEF,
	parameter int VALUE_WIDTH = idll_pkg::VALUE_WIDTH_DEF,
	localparam int AW = $clog2(NODE_DEPTH)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  idll_pkg::ctl_t                ctl,
	input  idll_pkg::idx_t                node_index,
	input  logic signed [VALUE_WIDTH-1:0] node_value,
	input  idll_pkg::idx_t                link_next,
	input  idll_pkg::idx_t                link_prev,
	input  logic [idll_pkg::NCW-1:0]      node_count,
	input  logic [VALUE_WIDTH-1:0]        rval,
	input  idll_pkg::idx_t                rnext,
	input  idll_pkg::idx_t                rprev,
	output logic [AW-1:0]                 addr,
	output idll_pkg::we_t                 we,
	output logic [VALUE_WIDTH-1:0]        wval,
	output idll_pkg::idx_t                wnext,
	output idll_pkg::idx_t                wprev,
	output logic                          chk_fail,
	output logic signed [VALUE_WIDTH-1:0] out_value,
	output idll_pkg::idx_t                out_index,
	output idll_pkg::idx_t                out_next,
	output idll_pkg::idx_t                out_prev,
	output idll_pkg::idx_t                head_index,
	output idll_pkg::idx_t                tail_index,
	output idll_pkg::status_t             status
);
	import idll_pkg::*;

	localparam int CW = $clog2(NODE_DEPTH + 1);

	uword_t uw;
	logic   ok;

	idx_t             idx_q, lnext_q, lprev_q;
	logic [NCW-1:0]   cnt_q;
	logic [VALUE_WIDTH-1:0] val_q;
	idx_t             head_q, tail_q;
	logic [CW-1:0]    free_q;
	idx_t             nx_q, pv_q;

	logic [VALUE_WIDTH-1:0] res_val_q, res_val_d;
	idx_t             res_idx_q, res_idx_d, res_next_q, res_next_d, res_prev_q, res_prev_d;
	status_t          status_q, status_d, fail_code;
	idx_t             head_d, tail_d;
	idx_t             free_idx;

	assign uw       = ctl.uw;
	assign free_idx = idx_t'(IW'(free_q));

	// range and capacity checks of the current step
	always_comb begin
		chk_fail  = 1'b0;
		fail_code = ST_RANGE;
		case (uw.chk)
			CHK_ENDS: chk_fail = !is_link(lnext_q, NODE_DEPTH) ||
				!is_link(lprev_q, NODE_DEPTH) || (int'(cnt_q) > NODE_DEPTH);
			CHK_LOAD: chk_fail = !is_node(idx_q, NODE_DEPTH) ||
				!is_link(lnext_q, NODE_DEPTH) || !is_link(lprev_q, NODE_DEPTH);
			CHK_NODE: chk_fail = !is_node(idx_q, NODE_DEPTH);
			CHK_INSERT: begin
				if (!is_link(idx_q, NODE_DEPTH)) begin
					chk_fail = 1'b1;
				end else if (int'(free_q) >= NODE_DEPTH) begin
					chk_fail  = 1'b1;
					fail_code = ST_FULL;
				end
			end
			default: chk_fail = 1'b0;
		endcase
	end

	assign ok = ctl.en && !chk_fail;

	// select store address and write data
	always_comb begin
		case (uw.addr)
			ADDR_IDX:  addr = AW'(idx_q);
			ADDR_FREE: addr = AW'(free_q);
			ADDR_PV:   addr = AW'(pv_q);
			ADDR_NX:   addr = AW'(nx_q);
			default:   addr = AW'(idx_q);
		endcase
		case (uw.wr_next)
			WN_LNEXT: wnext = lnext_q;
			WN_NX:    wnext = nx_q;
			WN_NEW:   wnext = free_idx;
			default:  wnext = NONE_IDX;
		endcase
		case (uw.wr_prev)
			WP_LPREV: wprev = lprev_q;
			WP_PV:    wprev = pv_q;
			WP_NEW:   wprev = free_idx;
			default:  wprev = NONE_IDX;
		endcase
		wval   = val_q;
		we.val = ok && uw.wr_val;
		we.nxt = ok && (uw.wr_next != WN_NONE) &&
			((uw.act != ACT_HEAD_LINK) || is_node(pv_q, NODE_DEPTH));
		we.prv = ok && (uw.wr_prev != WP_NONE) &&
			((uw.act != ACT_TAIL_LINK) || is_node(nx_q, NODE_DEPTH));
	end

	// next list ends and result fields
	always_comb begin
		head_d     = head_q;
		tail_d     = tail_q;
		res_val_d  = res_val_q;
		res_idx_d  = res_idx_q;
		res_next_d = res_next_q;
		res_prev_d = res_prev_q;
		status_d   = status_q;
		if (ctl.en && chk_fail) status_d = fail_code;
		if (ok) begin
			case (uw.act)
				ACT_SET_ENDS: begin
					head_d = lnext_q;
					tail_d = lprev_q;
				end
				ACT_HEAD_LINK: if (!is_node(pv_q, NODE_DEPTH)) head_d = wnext;
				ACT_TAIL_LINK: if (!is_node(nx_q, NODE_DEPTH)) tail_d = wprev;
				ACT_GRAB_DEL:  res_val_d = rval;
				ACT_GRAB_READ: begin
					res_val_d  = rval;
					res_next_d = rnext;
					res_prev_d = rprev;
				end
				default: res_val_d = res_val_q;
			endcase
			if (uw.bump) res_idx_d = free_idx;
		end
	end

	// hold list ends and the free counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= NONE_IDX;
			tail_q <= NONE_IDX;
			free_q <= '0;
		end else if (ok) begin
			head_q <= head_d;
			tail_q <= tail_d;
			if (uw.act == ACT_SET_ENDS) free_q <= CW'(cnt_q);
			else if (uw.bump) free_q <= free_q + CW'(1);
		end
	end

	// latch the request, work links and partial results
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			idx_q      <= node_index;
			val_q      <= node_value;
			lnext_q    <= link_next;
			lprev_q    <= link_prev;
			cnt_q      <= node_count;
			res_val_q  <= '0;
			res_idx_q  <= NONE_IDX;
			res_next_q <= NONE_IDX;
			res_prev_q <= NONE_IDX;
			status_q   <= ST_OK;
		end else if (ctl.en) begin
			res_val_q  <= res_val_d;
			res_idx_q  <= res_idx_d;
			res_next_q <= res_next_d;
			res_prev_q <= res_prev_d;
			status_q   <= status_d;
			if (ok) begin
				case (uw.act)
					ACT_GRAB_DEL: begin
						nx_q <= rnext;
						pv_q <= rprev;
					end
					ACT_GRAB_AFTER: begin
						pv_q <= idx_q;
						nx_q <= (idx_q == NONE_IDX) ? head_q : rnext;
					end
					ACT_GRAB_BEFORE: begin
						nx_q <= idx_q;
						pv_q <= (idx_q == NONE_IDX) ? tail_q : rprev;
					end
					default: nx_q <= nx_q;
				endcase
			end
		end
	end

	// load the result register on the finishing step
	always_ff @(posedge clk) begin
		if (ctl.en && ctl.finish) begin
			out_value  <= res_val_d;
			out_index  <= res_idx_d;
			out_next   <= res_next_d;
			out_prev   <= res_prev_d;
			head_index <= head_d;
			tail_index <= tail_d;
			status     <= status_d;
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the indexed doubly linked list core: queued requests, list predictor.
module testbench;
	import idll_pkg::*;

	localparam int DEPTH        = NODE_DEPTH_DEF;
	localparam int VW           = VALUE_WIDTH_DEF;
	localparam int TOTAL_ITEMS  = 1550;
	localparam int BLOCK_ITEMS  = 190;
	localparam int QUIET_LIMIT  = 4000;
	localparam int REPORT_MAX   = 10;
	localparam int TAIL_CYCLES  = 20;

	// kinds the core treats as no-ops
	localparam logic [KW-1:0] KIND_SPARE_A = KW'(6);
	localparam logic [KW-1:0] KIND_SPARE_B = KW'(7);

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct {
		logic [KW-1:0]        kind;
		idx_t                 idx;
		logic signed [VW-1:0] val;
		idx_t                 lnext;
		idx_t                 lprev;
		logic [NCW-1:0]       cnt;
	} list_req_t;

	typedef struct {
		logic signed [VW-1:0] val;
		idx_t                 slot;
		idx_t                 nxt;
		idx_t                 prv;
		idx_t                 head;
		idx_t                 tail;
		status_t              st;
	} list_rsp_t;

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 in_valid   = 1'b0;
	logic                 in_stall;
	logic [KW-1:0]        kind       = '0;
	idx_t                 node_index = '0;
	logic signed [VW-1:0] node_value = '0;
	idx_t                 link_next  = '0;
	idx_t                 link_prev  = '0;
	logic [NCW-1:0]       node_count = '0;
	logic                 out_valid;
	logic                 out_stall  = 1'b0;
	logic signed [VW-1:0] out_value;
	idx_t                 out_index;
	idx_t                 out_next;
	idx_t                 out_prev;
	idx_t                 head_index;
	idx_t                 tail_index;
	status_t              status;

	indexed_doubly_linked_list u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.node_index (node_index),
		.node_value (node_value),
		.link_next  (link_next),
		.link_prev  (link_prev),
		.node_count (node_count),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_value  (out_value),
		.out_index  (out_index),
		.out_next   (out_next),
		.out_prev   (out_prev),
		.head_index (head_index),
		.tail_index (tail_index),
		.status     (status)
	);

	always #5 clk = ~clk;

	// predicted list state
	logic signed [VW-1:0] store_val [DEPTH];
	idx_t                 store_nxt [DEPTH];
	idx_t                 store_prv [DEPTH];
	idx_t                 list_head = NONE_IDX;
	idx_t                 list_tail = NONE_IDX;
	int                   list_free = 0;

	// stimulus-side bookkeeping: which entries are safe to look up
	bit        gen_written [DEPTH];
	int        gen_wlist [$];
	int        gen_live [$];
	int        gen_free = 0;
	int        issued = 0;

	list_req_t  pending_requests [$];
	list_rsp_t  awaited_results [$];
	list_req_t  held_req;
	list_rsp_t  fresh_rsp;
	list_rsp_t  want;
	idle_mode_t mode = IDLE_NONE;

	int fail_count   = 0;
	int report_count = 0;
	int checked      = 0;
	int quiet_cycles = 0;
	int full_hits    = 0;
	int range_hits   = 0;
	int kind_hits [8];

	function automatic bit in_store(input int i);
		return i >= 0 && i < DEPTH;
	endfunction

	function automatic bit end_or_node(input int i);
		return i == -1 || in_store(i);
	endfunction

	// apply one request to the predicted list and return the result it gives
	function automatic list_rsp_t list_apply(input list_req_t rq);
		list_rsp_t rs;
		int ix, ln, lp, nx, pv, n;
		rs.val  = '0;
		rs.slot = NONE_IDX;
		rs.nxt  = NONE_IDX;
		rs.prv  = NONE_IDX;
		rs.st   = ST_OK;
		ix = rq.idx;
		ln = rq.lnext;
		lp = rq.lprev;
		case (rq.kind)
			KIND_SET_ENDS: begin
				if (!end_or_node(ln) || !end_or_node(lp) || int'(rq.cnt) > DEPTH) begin
					rs.st = ST_RANGE;
				end else begin
					list_head = rq.lnext;
					list_tail = rq.lprev;
					list_free = int'(rq.cnt);
				end
			end
			KIND_LOAD: begin
				if (!in_store(ix) || !end_or_node(ln) || !end_or_node(lp)) begin
					rs.st = ST_RANGE;
				end else begin
					store_val[ix] = rq.val;
					store_nxt[ix] = rq.lnext;
					store_prv[ix] = rq.lprev;
				end
			end
			KIND_DELETE: begin
				if (!in_store(ix)) begin
					rs.st = ST_RANGE;
				end else begin
					nx = store_nxt[ix];
					pv = store_prv[ix];
					rs.val = store_val[ix];
					// unlink; a missing neighbour moves the list end instead
					if (in_store(pv)) store_nxt[pv] = idx_t'(nx);
					else list_head = idx_t'(nx);
					if (in_store(nx)) store_prv[nx] = idx_t'(pv);
					else list_tail = idx_t'(pv);
				end
			end
			KIND_INS_AFTER, KIND_INS_BEFOR: begin
				if (!end_or_node(ix)) begin
					rs.st = ST_RANGE;
				end else if (list_free >= DEPTH) begin
					rs.st = ST_FULL;
				end else begin
					n = list_free;
					if (rq.kind == KIND_INS_AFTER) begin
						pv = ix;
						if (ix == -1) nx = list_head;
						else nx = store_nxt[ix];
					end else begin
						nx = ix;
						if (ix == -1) pv = list_tail;
						else pv = store_prv[ix];
					end
					store_val[n] = rq.val;
					store_nxt[n] = idx_t'(nx);
					store_prv[n] = idx_t'(pv);
					if (in_store(pv)) store_nxt[pv] = idx_t'(n);
					else list_head = idx_t'(n);
					if (in_store(nx)) store_prv[nx] = idx_t'(n);
					else list_tail = idx_t'(n);
					list_free++;
					rs.slot = idx_t'(n);
				end
			end
			KIND_READ: begin
				if (!in_store(ix)) begin
					rs.st = ST_RANGE;
				end else begin
					rs.val = store_val[ix];
					rs.nxt = store_nxt[ix];
					rs.prv = store_prv[ix];
				end
			end
			default: ;
		endcase
		rs.head = list_head;
		rs.tail = list_tail;
		return rs;
	endfunction

	function automatic int rand11();
		return int'($urandom_range(2047)) - 1024;
	endfunction

	function automatic int pick_live();
		if (gen_live.size() == 0) return -1;
		return gen_live[$urandom_range(gen_live.size() - 1)];
	endfunction

	// out of range when nothing has been written yet
	function automatic int pick_written();
		if (gen_wlist.size() == 0) return -2;
		return gen_wlist[$urandom_range(gen_wlist.size() - 1)];
	endfunction

	function automatic void mark_written(input int i);
		if (!gen_written[i]) begin
			gen_written[i] = 1'b1;
			gen_wlist.push_back(i);
		end
	endfunction

	// queue one request, steering lookups away from entries never written
	task automatic push_req(input logic [KW-1:0] k, input int ix, input logic [VW-1:0] v,
		input int ln, input int lp, input int cnt);
		list_req_t rq;
		int hits [$];
		if ((k == KIND_DELETE || k == KIND_READ) && in_store(ix) && !gen_written[ix])
			ix = pick_written();
		if ((k == KIND_INS_AFTER || k == KIND_INS_BEFOR) && in_store(ix) && !gen_written[ix])
			ix = -1;
		case (k)
			KIND_SET_ENDS: begin
				if (end_or_node(ln) && end_or_node(lp) && cnt <= DEPTH) begin
					gen_free = cnt;
					gen_live.delete();
				end
			end
			KIND_LOAD: begin
				if (in_store(ix) && end_or_node(ln) && end_or_node(lp)) mark_written(ix);
			end
			KIND_DELETE: begin
				hits = gen_live.find_first_index(x) with (x == ix);
				if (hits.size() > 0) gen_live.delete(hits[0]);
			end
			KIND_INS_AFTER, KIND_INS_BEFOR: begin
				if (end_or_node(ix) && gen_free < DEPTH) begin
					mark_written(gen_free);
					gen_live.push_back(gen_free);
					gen_free++;
				end
			end
			default: ;
		endcase
		rq.kind  = k;
		rq.idx   = idx_t'(ix);
		rq.val   = v;
		rq.lnext = idx_t'(ln);
		rq.lprev = idx_t'(lp);
		rq.cnt   = NCW'(cnt);
		pending_requests.push_back(rq);
		issued++;
	endtask

	// fresh empty list, then a burst of mostly well-formed list operations
	task automatic run_session();
		int len, r, c, ix;
		r = $urandom_range(99);
		if (r < 10) c = $urandom_range(DEPTH, DEPTH - 4);
		else c = $urandom_range(600);
		push_req(KIND_SET_ENDS, rand11(), $urandom, -1, -1, c);
		len = $urandom_range(60, 15);
		repeat (len) begin
			r = $urandom_range(99);
			if (r < 50) begin
				if ($urandom_range(99) < 20) ix = -1;
				else ix = pick_live();
				push_req((r < 25) ? KIND_INS_AFTER : KIND_INS_BEFOR, ix, $urandom,
					rand11(), rand11(), $urandom_range(2047));
			end else if (r < 65) begin
				ix = pick_live();
				if (ix < 0) ix = pick_written();
				push_req(KIND_DELETE, ix, $urandom, rand11(), rand11(), $urandom_range(2047));
			end else if (r < 85) begin
				if ($urandom_range(99) < 70) ix = pick_live();
				else ix = pick_written();
				if (ix < 0) ix = pick_written();
				push_req(KIND_READ, ix, $urandom, rand11(), rand11(), $urandom_range(2047));
			end else if (r < 90) begin
				push_req(KIND_LOAD, $urandom_range(DEPTH - 1), $urandom, pick_live(),
					pick_live(), $urandom_range(2047));
			end else begin
				push_req(KW'($urandom_range(7)), rand11(), $urandom, rand11(), rand11(),
					$urandom_range(2047));
			end
		end
	endtask

	task automatic wait_drained();
		while (pending_requests.size() != 0 || in_valid || awaited_results.size() != 0)
			@(negedge clk);
	endtask

	// driver: present queued requests, predict each one as it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				fresh_rsp = list_apply(held_req);
				awaited_results.push_back(fresh_rsp);
				kind_hits[held_req.kind]++;
				if (fresh_rsp.st == ST_FULL) full_hits++;
				if (fresh_rsp.st == ST_RANGE) range_hits++;
			end
			// advance to the next request once the held one is gone
			if (!in_valid || !in_stall) begin
				if (pending_requests.size() > 0 && $urandom_range(99) >=
					((mode == IDLE_SEND) ? 79 : (mode == IDLE_BOTH) ? 36 : 0)) begin
					held_req = pending_requests.pop_front();
					in_valid   <= 1'b1;
					kind       <= held_req.kind;
					node_index <= held_req.idx;
					node_value <= held_req.val;
					link_next  <= held_req.lnext;
					link_prev  <= held_req.lprev;
					node_count <= held_req.cnt;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each result against the oldest prediction, stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					fail_count++;
					if (report_count < REPORT_MAX)
						$display("unexpected result: value %0d index %0d status %0d",
							out_value, out_index, status);
					report_count++;
				end else begin
					want = awaited_results.pop_front();
					checked++;
					if (out_value !== want.val || out_index !== want.slot ||
						out_next !== want.nxt || out_prev !== want.prv ||
						head_index !== want.head || tail_index !== want.tail ||
						status !== want.st) begin
						fail_count++;
						if (report_count < REPORT_MAX) begin
							$display("mismatch on result %0d", checked);
							$display("  expected value %0d index %0d next %0d prev %0d head %0d tail %0d status %0d",
								want.val, want.slot, want.nxt, want.prv, want.head,
								want.tail, want.st);
							$display("  actual   value %0d index %0d next %0d prev %0d head %0d tail %0d status %0d",
								out_value, out_index, out_next, out_prev, head_index,
								tail_index, status);
						end
						report_count++;
					end
				end
			end
			out_stall <= ($urandom_range(99) <
				((mode == IDLE_RECV) ? 79 : (mode == IDLE_BOTH) ? 36 : 0));
		end
	end

	// watchdog: end the run when neither channel moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("no handshake for %0d cycles", QUIET_LIMIT);
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		int blk, start;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: ends of ranges, every kind, unlink at head and tail, full store
		push_req(KIND_READ, -2, '0, 0, 0, 0);
		push_req(KIND_DELETE, -1, '0, 0, 0, 0);
		push_req(KIND_INS_AFTER, -1, 32'h7FFF_FFFF, 0, 0, 0);
		push_req(KIND_INS_BEFOR, -1, 32'h8000_0000, 0, 0, 0);
		push_req(KIND_INS_AFTER, 0, 32'hFFFF_FFFF, 0, 0, 0);
		push_req(KIND_INS_BEFOR, 0, 32'h0000_0000, 0, 0, 0);
		push_req(KIND_READ, 2, '0, 0, 0, 0);
		push_req(KIND_READ, 3, '0, 0, 0, 0);
		push_req(KIND_DELETE, 3, '0, 0, 0, 0);
		push_req(KIND_DELETE, 1, '0, 0, 0, 0);
		push_req(KIND_DELETE, 2, '0, 0, 0, 0);
		push_req(KIND_READ, 3, '0, 0, 0, 0);
		push_req(KIND_LOAD, DEPTH - 1, 32'h5A5A_5A5A, -1, DEPTH - 1, 0);
		push_req(KIND_LOAD, -1024, 32'hFFFF_FFFF, -1, -1, 0);
		push_req(KIND_LOAD, 5, 32'h1234_5678, -2, 0, 0);
		push_req(KIND_SET_ENDS, 0, '0, DEPTH - 1, DEPTH - 1, DEPTH + 1);
		push_req(KIND_SET_ENDS, 0, '0, -1024, -1, 0);
		push_req(KIND_SET_ENDS, 0, '0, -1, -1, 2047);
		push_req(KIND_SET_ENDS, 0, '0, 0, 0, DEPTH - 1);
		push_req(KIND_INS_BEFOR, -1, 32'h0F0F_0F0F, 0, 0, 0);
		push_req(KIND_INS_AFTER, -1, 32'hF0F0_F0F0, 0, 0, 0);
		push_req(KIND_INS_BEFOR, DEPTH - 1, 32'h1111_1111, 0, 0, 0);
		push_req(KIND_INS_AFTER, -3, 32'h2222_2222, 0, 0, 0);
		push_req(KIND_SPARE_A, rand11(), $urandom, rand11(), rand11(), $urandom_range(2047));
		push_req(KIND_SPARE_B, rand11(), $urandom, rand11(), rand11(), $urandom_range(2047));
		push_req(KIND_READ, DEPTH - 1, '0, 0, 0, 0);
		push_req(KIND_SET_ENDS, 0, '0, -1, -1, 0);
		wait_drained();

		// random: rotate through the idle and stall mixes block by block
		blk = 0;
		while (issued < TOTAL_ITEMS) begin
			mode = idle_mode_t'(blk % 4);
			start = issued;
			while (issued - start < BLOCK_ITEMS && issued < TOTAL_ITEMS) run_session();
			wait_drained();
			blk++;
		end

		repeat (TAIL_CYCLES) @(negedge clk);
		fail_count += awaited_results.size();
		$display("Covered %0d requests: %0d inserts, %0d deletes, %0d reads, %0d loads, %0d set-ends, %0d spare kinds.",
			issued, kind_hits[KIND_INS_AFTER] + kind_hits[KIND_INS_BEFOR],
			kind_hits[KIND_DELETE], kind_hits[KIND_READ], kind_hits[KIND_LOAD],
			kind_hits[KIND_SET_ENDS], kind_hits[KIND_SPARE_A] + kind_hits[KIND_SPARE_B]);
		$display("%0d results checked under four idle/stall mixes; %0d full and %0d range rejections; %0d failures.",
			checked, full_hits, range_hits, fail_count);
		if (fail_count == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

endmodule
